FILE: design/pfns_pkg.sv
package pfns_pkg;

    localparam int MAX_RUN_FRAMES = 256;
    localparam int CNT_W          = $clog2(MAX_RUN_FRAMES + 1);
    localparam int NOTE_COUNT     = 128;
    localparam int CFG_IDX_W      = 8;
    localparam int POW_W          = 600;

    typedef logic [23:0] freq_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CLARITY  = 8'd0,
        CFG_MAX_GAP      = 8'd1,
        CFG_MIN_DURATION = 8'd2,
        CFG_HOP_LENGTH   = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic insert;
        logic shift;
    } chain_cmd_t;

    typedef freq_t thresh_tab_t [NOTE_COUNT];

    // smallest frequency x with x^24 >= 55^24 * 2^(125+2n)
    function automatic freq_t note_threshold(int n);
        logic [POW_W-1:0] q;
        logic [POW_W-1:0] p;
        logic [24:0]      lo;
        logic [24:0]      hi;
        logic [24:0]      mid;
        q  = POW_W'(1);
        for (int i = 0; i < 24; i++)
        begin
            q = q * POW_W'(55);
        end
        q  = q << (125 + 2 * n);
        lo = 25'd0;
        hi = 25'h1000000;
        for (int k = 0; k < 26; k++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                p   = POW_W'(1);
                for (int i = 0; i < 24; i++)
                begin
                    p = p * POW_W'(mid);
                end
                if (p >= q)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 25'd1;
                end
            end
        end
        return lo[23:0];
    endfunction

    function automatic thresh_tab_t build_thresholds();
        thresh_tab_t t;
        t[0] = '0;
        for (int n = 1; n < NOTE_COUNT; n++)
        begin
            t[n] = note_threshold(n);
        end
        return t;
    endfunction

    localparam thresh_tab_t NOTE_THRESH = build_thresholds();

endpackage

FILE: design/pfns_if.sv
interface pfns_in_if;
    import pfns_pkg::*;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        voiced;
    logic [15:0] clarity;
    freq_t       frequency;
    logic [31:0] frame_time;
    modport source(output valid, opcode, voiced, clarity, frequency, frame_time, input ready);
    modport sink(input valid, opcode, voiced, clarity, frequency, frame_time, output ready);
endinterface

interface pfns_out_if;
    import pfns_pkg::*;
    logic        valid;
    logic        ready;
    logic [6:0]  note_number;
    logic [31:0] start_time;
    logic [31:0] duration;
    logic [15:0] mean_clarity;
    logic [15:0] frames_in_note;
    freq_t       median_frequency;
    modport source(output valid, note_number, start_time, duration, mean_clarity,
                   frames_in_note, median_frequency, input ready);
    modport sink(input valid, note_number, start_time, duration, mean_clarity,
                 frames_in_note, median_frequency, output ready);
endinterface

interface pfns_cfg_if;
    import pfns_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: design/pfns_cell.sv
module pfns_cell (
    input  logic               clk,
    input  pfns_pkg::chain_cmd_t cmd,
    input  pfns_pkg::freq_t    ins_val,
    input  logic               occupied,
    input  logic               left_gt,
    input  pfns_pkg::freq_t    left_val,
    input  pfns_pkg::freq_t    right_val,
    output pfns_pkg::freq_t    val,
    output logic               gt
);
    import pfns_pkg::*;

    freq_t val_reg;
    freq_t val_next;

    assign gt  = !occupied || (val_reg > ins_val);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.load)
        begin
            val_next = ins_val;
        end
        else if (cmd.insert && gt)
        begin
            val_next = left_gt ? left_val : ins_val;
        end
        else if (cmd.shift)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: design/pfns_chain.sv
module pfns_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfns_pkg::chain_cmd_t cmd,
    input  pfns_pkg::freq_t      ins_val,
    output pfns_pkg::cnt_t       count,
    output pfns_pkg::freq_t      head
);
    import pfns_pkg::*;

    cnt_t  count_reg;
    cnt_t  count_next;
    freq_t val_w [MAX_RUN_FRAMES];
    logic  gt_w  [MAX_RUN_FRAMES];

    // sorted ascending, cell 0 holds the smallest
    for (genvar i = 0; i < MAX_RUN_FRAMES; i++)
    begin : g_cell
        logic  occ;
        logic  lgt;
        freq_t lval;
        freq_t rval;
        assign occ = cnt_t'(i) < count_reg;
        if (i == 0)
        begin : g_first
            assign lgt  = 1'b0;
            assign lval = '0;
        end
        else
        begin : g_mid
            assign lgt  = gt_w[i-1];
            assign lval = val_w[i-1];
        end
        if (i == MAX_RUN_FRAMES - 1)
        begin : g_last
            assign rval = '0;
        end
        else
        begin : g_inner
            assign rval = val_w[i+1];
        end
        pfns_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .ins_val   (ins_val),
            .occupied  (occ),
            .left_gt   (lgt),
            .left_val  (lval),
            .right_val (rval),
            .val       (val_w[i]),
            .gt        (gt_w[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.load)
        begin
            count_next = cnt_t'(1);
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign head  = val_w[0];

endmodule

FILE: design/pfns_div.sv
module pfns_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    import pfns_pkg::*;

    logic [5:0]  step_reg;
    logic [5:0]  step_next;
    logic [31:0] quot_reg;
    logic [31:0] quot_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] dvs_reg;
    logic [15:0] dvs_next;
    logic [16:0] trial;

    // restoring, one quotient bit per cycle
    always_comb
    begin
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[31]};
        if (start)
        begin
            step_next = 6'd32;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (step_reg != 6'd0)
        begin
            step_next = step_reg - 6'd1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = 16'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[15:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = step_reg != 6'd0;
    assign quotient = quot_reg;

endmodule

FILE: design/pitch_frame_note_segmenter.sv
// pitch frame note segmenter
// frame_in: pitch frames and end-of-stream items, a transfer on valid and ready.
// event_out: one note event per closed run that is long enough.
// cfg: register writes (index, data), always ready; write only while idle.
// frame_in.ready is high only while the block is idle; it works on one item
// at a time. An unusable frame is handled in the idle step; a zero hop length
// drops every item. A usable frame goes through a 7-step binary search over
// the note threshold table, then, if its note matches the open run, the
// update of the run and, while the row has room, one insertion into the
// sorted cell row. Closing a run with an event shifts the sorted row down to
// the median rank while the 32-step clarity divider runs.
// The event sits in an output register; the block takes the next item while
// it waits. If another event is due while the receiver still stalls, the
// block holds in its emit step until the register frees.
// Reset clears the run and sets the registers to their defaults; the cell
// row needs no clearing pass.
module pitch_frame_note_segmenter (
    input logic       clk,
    input logic       rst_n,
    pfns_in_if.sink   frame_in,
    pfns_out_if.source event_out,
    pfns_cfg_if.sink  cfg
);
    import pfns_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NOTE,
        S_DECIDE,
        S_CLOSE,
        S_MED,
        S_EMIT,
        S_FINISH
    } state_t;

    state_t      state_reg,        state_next;
    logic [15:0] min_clarity_reg,  min_clarity_next;
    logic [7:0]  max_gap_reg,      max_gap_next;
    logic [31:0] min_duration_reg, min_duration_next;
    logic [15:0] hop_length_reg,   hop_length_next;
    logic        run_active_reg,   run_active_next;
    logic [6:0]  run_note_reg,     run_note_next;
    logic [31:0] run_start_reg,    run_start_next;
    logic [31:0] run_end_reg,      run_end_next;
    logic [31:0] clar_sum_reg,     clar_sum_next;
    logic [15:0] frame_cnt_reg,    frame_cnt_next;
    logic [8:0]  gap_cnt_reg,      gap_cnt_next;
    logic [2:0]  bit_cnt_reg,      bit_cnt_next;
    logic [6:0]  note_acc_reg,     note_acc_next;
    logic        open_after_reg,   open_after_next;
    cnt_t        shift_cnt_reg,    shift_cnt_next;
    logic        out_valid_reg,    out_valid_next;

    freq_t       freq_reg,  freq_next;
    logic [15:0] clar_reg,  clar_next;
    logic [31:0] time_reg,  time_next;

    logic [6:0]  o_note_reg,   o_note_next;
    logic [31:0] o_start_reg,  o_start_next;
    logic [31:0] o_dur_reg,    o_dur_next;
    logic [15:0] o_mean_reg,   o_mean_next;
    logic [15:0] o_frames_reg, o_frames_next;
    freq_t       o_med_reg,    o_med_next;

    chain_cmd_t  chain_cmd;
    cnt_t        chain_count;
    freq_t       chain_head;
    logic        div_start;
    logic        div_busy;
    logic [31:0] div_quot;

    logic        in_xfer;
    logic        usable;
    logic [32:0] dur_full;
    logic [32:0] end_sum;
    logic [31:0] frame_end;
    logic [32:0] clar_add;
    logic [8:0]  gap_inc;
    logic [6:0]  note_cand;
    logic        emit_ok;
    logic        out_free;

    pfns_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (chain_cmd),
        .ins_val (freq_reg),
        .count   (chain_count),
        .head    (chain_head)
    );

    pfns_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clar_sum_reg),
        .divisor  (frame_cnt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign frame_in.ready = state_reg == S_IDLE;
    assign in_xfer        = frame_in.valid && frame_in.ready;
    assign usable         = frame_in.voiced && (frame_in.clarity >= min_clarity_reg);
    assign cfg.ready      = 1'b1;

    assign dur_full  = {1'b0, run_end_reg} - {1'b0, run_start_reg};
    assign end_sum   = {1'b0, time_reg} + {17'd0, hop_length_reg};
    assign frame_end = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    assign clar_add  = {1'b0, clar_sum_reg} + {17'd0, clar_reg};
    assign gap_inc   = (gap_cnt_reg == 9'd256) ? gap_cnt_reg : gap_cnt_reg + 9'd1;
    assign note_cand = note_acc_reg | (7'd1 << bit_cnt_reg);
    assign emit_ok   = run_active_reg && (frame_cnt_reg != 16'd0) && !dur_full[32]
                       && (dur_full[31:0] >= min_duration_reg);
    assign out_free  = !out_valid_reg || event_out.ready;

    always_comb
    begin
        state_next        = state_reg;
        min_clarity_next  = min_clarity_reg;
        max_gap_next      = max_gap_reg;
        min_duration_next = min_duration_reg;
        hop_length_next   = hop_length_reg;
        run_active_next   = run_active_reg;
        run_note_next     = run_note_reg;
        run_start_next    = run_start_reg;
        run_end_next      = run_end_reg;
        clar_sum_next     = clar_sum_reg;
        frame_cnt_next    = frame_cnt_reg;
        gap_cnt_next      = gap_cnt_reg;
        bit_cnt_next      = bit_cnt_reg;
        note_acc_next     = note_acc_reg;
        open_after_next   = open_after_reg;
        shift_cnt_next    = shift_cnt_reg;
        out_valid_next    = out_valid_reg;
        freq_next         = freq_reg;
        clar_next         = clar_reg;
        time_next         = time_reg;
        o_note_next       = o_note_reg;
        o_start_next      = o_start_reg;
        o_dur_next        = o_dur_reg;
        o_mean_next       = o_mean_reg;
        o_frames_next     = o_frames_reg;
        o_med_next        = o_med_reg;
        chain_cmd         = '0;
        div_start         = 1'b0;

        if (event_out.valid && event_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_MIN_CLARITY:  min_clarity_next  = cfg.data[15:0];
                CFG_MAX_GAP:      max_gap_next      = cfg.data[7:0];
                CFG_MIN_DURATION: min_duration_next = cfg.data;
                CFG_HOP_LENGTH:   hop_length_next   = cfg.data[15:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && hop_length_reg != 16'd0)
                begin
                    freq_next = frame_in.frequency;
                    clar_next = frame_in.clarity;
                    time_next = frame_in.frame_time;
                    if (frame_in.opcode)
                    begin
                        gap_cnt_next    = '0;
                        open_after_next = 1'b0;
                        state_next      = S_CLOSE;
                    end
                    else if (!usable)
                    begin
                        if (run_active_reg)
                        begin
                            gap_cnt_next = gap_inc;
                            if (gap_inc > {1'b0, max_gap_reg})
                            begin
                                open_after_next = 1'b0;
                                state_next      = S_CLOSE;
                            end
                        end
                    end
                    else
                    begin
                        bit_cnt_next  = 3'd6;
                        note_acc_next = '0;
                        state_next    = S_NOTE;
                    end
                end
            end
            S_NOTE:
            begin
                if (freq_reg >= NOTE_THRESH[note_cand])
                begin
                    note_acc_next = note_cand;
                end
                if (bit_cnt_reg == 3'd0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 3'd1;
                end
            end
            S_DECIDE:
            begin
                if (run_active_reg && note_acc_reg == run_note_reg)
                begin
                    gap_cnt_next = '0;
                    if (frame_cnt_reg < 16'(MAX_RUN_FRAMES))
                    begin
                        chain_cmd.insert = 1'b1;
                    end
                    if (frame_cnt_reg != 16'hFFFF)
                    begin
                        frame_cnt_next = frame_cnt_reg + 16'd1;
                    end
                    clar_sum_next = clar_add[32] ? 32'hFFFF_FFFF : clar_add[31:0];
                    run_end_next  = frame_end;
                    state_next    = S_IDLE;
                end
                else
                begin
                    open_after_next = 1'b1;
                    state_next      = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (emit_ok)
                begin
                    div_start      = 1'b1;
                    shift_cnt_next = chain_count >> 1;
                    state_next     = S_MED;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MED:
            begin
                if (shift_cnt_reg != '0)
                begin
                    chain_cmd.shift = 1'b1;
                    shift_cnt_next  = shift_cnt_reg - cnt_t'(1);
                end
                else if (!div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_note_next    = run_note_reg;
                    o_start_next   = run_start_reg;
                    o_dur_next     = dur_full[31:0];
                    o_mean_next    = (div_quot[31:16] != 16'd0) ? 16'hFFFF : div_quot[15:0];
                    o_frames_next  = frame_cnt_reg;
                    o_med_next     = chain_head;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (open_after_reg)
                begin
                    chain_cmd.load  = 1'b1;
                    run_active_next = 1'b1;
                    run_note_next   = note_acc_reg;
                    run_start_next  = time_reg;
                    run_end_next    = frame_end;
                    clar_sum_next   = {16'd0, clar_reg};
                    frame_cnt_next  = 16'd1;
                    gap_cnt_next    = '0;
                end
                else
                begin
                    chain_cmd.clear = 1'b1;
                    run_active_next = 1'b0;
                    clar_sum_next   = '0;
                    frame_cnt_next  = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            min_clarity_reg  <= 16'd0;
            max_gap_reg      <= 8'd2;
            min_duration_reg <= 32'd0;
            hop_length_reg   <= 16'd256;
            run_active_reg   <= 1'b0;
            run_note_reg     <= '0;
            run_start_reg    <= '0;
            run_end_reg      <= '0;
            clar_sum_reg     <= '0;
            frame_cnt_reg    <= '0;
            gap_cnt_reg      <= '0;
            bit_cnt_reg      <= '0;
            note_acc_reg     <= '0;
            open_after_reg   <= 1'b0;
            shift_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            min_clarity_reg  <= min_clarity_next;
            max_gap_reg      <= max_gap_next;
            min_duration_reg <= min_duration_next;
            hop_length_reg   <= hop_length_next;
            run_active_reg   <= run_active_next;
            run_note_reg     <= run_note_next;
            run_start_reg    <= run_start_next;
            run_end_reg      <= run_end_next;
            clar_sum_reg     <= clar_sum_next;
            frame_cnt_reg    <= frame_cnt_next;
            gap_cnt_reg      <= gap_cnt_next;
            bit_cnt_reg      <= bit_cnt_next;
            note_acc_reg     <= note_acc_next;
            open_after_reg   <= open_after_next;
            shift_cnt_reg    <= shift_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg     <= freq_next;
        clar_reg     <= clar_next;
        time_reg     <= time_next;
        o_note_reg   <= o_note_next;
        o_start_reg  <= o_start_next;
        o_dur_reg    <= o_dur_next;
        o_mean_reg   <= o_mean_next;
        o_frames_reg <= o_frames_next;
        o_med_reg    <= o_med_next;
    end

    assign event_out.valid            = out_valid_reg;
    assign event_out.note_number      = o_note_reg;
    assign event_out.start_time       = o_start_reg;
    assign event_out.duration         = o_dur_reg;
    assign event_out.mean_clarity     = o_mean_reg;
    assign event_out.frames_in_note   = o_frames_reg;
    assign event_out.median_frequency = o_med_reg;

`ifndef SYNTH
    a_active_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> frame_cnt_reg != 16'd0)
        else $error("open run without frames");

    a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !run_active_reg |-> chain_count == '0)
        else $error("sorted row holds values with no open run");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain_count <= cnt_t'(MAX_RUN_FRAMES))
        else $error("sorted row overfilled");

    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !div_busy && shift_cnt_reg == '0)
        else $error("event formed before median or mean ready");
`endif

endmodule
